### rtl/core/hlmdu_pkg.sv
// Package for the hi/lo multiply-divide unit: command codes.
// No dependencies.
`default_nettype none
package hlmdu_pkg;
    typedef enum logic [1:0] {
        CMD_MUL_S = 2'd0,
        CMD_MUL_U = 2'd1,
        CMD_DIV_S = 2'd2,
        CMD_DIV_U = 2'd3
    } cmd_t;
endpackage
`default_nettype wire

### rtl/core/hlmdu_if.sv
// Valid/ready channel interface carrying one word of a parameterized payload width.
// Depends on nothing; the payload width is set by the instantiating level.
`default_nettype none
interface hlmdu_if #(parameter int PW = 66);
    logic          valid;
    logic          ready;
    logic [PW-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/hi_lo_multiply_divide_unit_top.sv
// Top level of the hi/lo multiply-divide unit: multiplier pipeline, divider pipeline
// and output register. Depends on hlmdu_pkg, hlmdu_if and hlmdu_div_pipe.
`default_nettype none
// The unit accepts one word per cycle unless the output stalls and returns one
// result per word, in order. The pipeline depth is set by the divider, which
// resolves one quotient bit per stage; multiplies travel a matched
// delay line so results leave in order. Sign fix-up for signed multiplies uses
// the unsigned product less the opposite operand where an operand is negative.
// A stall on the output parks the finished result in a one-entry output register
// and freezes the whole pipeline until that result is taken, so input ready comes
// from a register and never from the output ready. The cycle in which the parked
// result leaves is a bubble on the input; with no output stall a word can enter
// every cycle.
module hi_lo_multiply_divide_unit_top
    import hlmdu_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input wire logic clk,
    input wire logic rst_n,
    hlmdu_if.sink    in_ch,
    hlmdu_if.source  out_ch
);
    localparam int DW = DATA_WIDTH;
    localparam int HW = (DW + 1) / 2;
    localparam int NS = DW + 1;

    typedef struct packed {
        logic [1:0]    command;
        logic [DW-1:0] operand_a;
        logic [DW-1:0] operand_b;
    } in_word_t;

    in_word_t iw;
    assign iw = in_word_t'(in_ch.data);

    // Pipeline advances while the output register is empty.
    logic [1:0] cnt_reg, cnt_next;
    logic       en;
    assign en = (cnt_reg == 2'd0);
    assign in_ch.ready = en;

    logic acc;
    assign acc = in_ch.valid & en;

    // Multiplier: partial products of half words, registered before summing.
    logic [DW-1:0] ma_reg, mb_reg;
    logic          msgn_reg;
    logic [2*DW-1:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic [DW-1:0] ma2_reg, mb2_reg;
    logic          msgn2_reg;
    logic [DW-1:0] ma3_reg, mb3_reg;
    logic          msgn3_reg;
    logic [2*DW-1:0] prod_reg;
    logic [DW-1:0] hi_fix;

    logic [DW-1:0] a_lo, a_hi, b_lo, b_hi;
    assign a_lo = {{(DW-HW){1'b0}}, ma_reg[HW-1:0]};
    assign a_hi = {{HW{1'b0}}, ma_reg[DW-1:HW]};
    assign b_lo = {{(DW-HW){1'b0}}, mb_reg[HW-1:0]};
    assign b_hi = {{HW{1'b0}}, mb_reg[DW-1:HW]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_reg   <= iw.operand_a;
            mb_reg   <= iw.operand_b;
            msgn_reg <= (iw.command == CMD_MUL_S);
            p00_reg  <= {{DW{1'b0}}, a_lo} * {{DW{1'b0}}, b_lo};
            p01_reg  <= ({{DW{1'b0}}, a_lo} * {{DW{1'b0}}, b_hi}) << HW;
            p10_reg  <= ({{DW{1'b0}}, a_hi} * {{DW{1'b0}}, b_lo}) << HW;
            p11_reg  <= ({{DW{1'b0}}, a_hi} * {{DW{1'b0}}, b_hi}) << (2 * HW);
            ma2_reg  <= ma_reg;
            mb2_reg  <= mb_reg;
            msgn2_reg <= msgn_reg;
            ma3_reg  <= ma2_reg;
            mb3_reg  <= mb2_reg;
            msgn3_reg <= msgn2_reg;
            prod_reg <= p00_reg + p01_reg + p10_reg + p11_reg;
        end
    end

    // Operands in the third stage line up with the summed product.
    always_comb
    begin
        hi_fix = prod_reg[2*DW-1:DW];
        if (msgn3_reg && ma3_reg[DW-1])
            hi_fix = hi_fix - mb3_reg;
        if (msgn3_reg && mb3_reg[DW-1])
            hi_fix = hi_fix - ma3_reg;
    end

    // Command flag travels with the divider; product waits in a delay line
    // whose stage numbers match the divider stages.
    logic          mulf_reg [NS];
    logic [DW-1:0] mhi_reg  [3:NS-1];
    logic [DW-1:0] mlo_reg  [3:NS-1];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mulf_reg[0] <= ~iw.command[1];
            for (int i = 1; i < NS; i++)
                mulf_reg[i] <= mulf_reg[i-1];
            mhi_reg[3] <= hi_fix;
            mlo_reg[3] <= prod_reg[DW-1:0];
            for (int i = 4; i < NS; i++)
            begin
                mhi_reg[i] <= mhi_reg[i-1];
                mlo_reg[i] <= mlo_reg[i-1];
            end
        end
    end

    logic          dv;
    logic [DW-1:0] dq, dr;
    hlmdu_div_pipe #(.DW(DW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (acc),
        .in_sgn    (iw.command == CMD_DIV_S),
        .in_a      (iw.operand_a),
        .in_b      (iw.operand_b),
        .out_valid (dv),
        .out_q     (dq),
        .out_r     (dr)
    );

    // Result select and one-entry output register.
    logic [2*DW-1:0] res;
    assign res = mulf_reg[NS-1] ? {mhi_reg[NS-1], mlo_reg[NS-1]} : {dr, dq};

    logic [2*DW-1:0] q0_reg, q0_next;
    logic            pop, push;
    assign push = dv & en;
    assign out_ch.valid = (cnt_reg != 2'd0) | push;
    assign out_ch.data  = (cnt_reg != 2'd0) ? q0_reg : res;
    assign pop = out_ch.valid & out_ch.ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        q0_next  = q0_reg;
        if (cnt_reg == 2'd0)
        begin
            if (push && !pop)
            begin
                q0_next  = res;
                cnt_next = 2'd1;
            end
        end
        else if (pop)
        begin
            cnt_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
    end
endmodule
`default_nettype wire

### rtl/core/hlmdu_div_pipe.sv
// Pipelined restoring divider: one quotient bit per stage, plus sign handling.
// Depends on hlmdu_pkg.
`default_nettype none
module hlmdu_div_pipe
    import hlmdu_pkg::*;
#(
    parameter int DW = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic          in_sgn,
    input  wire logic [DW-1:0] in_a,
    input  wire logic [DW-1:0] in_b,
    output logic               out_valid,
    output logic [DW-1:0]      out_q,
    output logic [DW-1:0]      out_r
);
    localparam int NS = DW + 1;

    typedef struct packed {
        logic          aneg;
        logic          qneg;
        logic          bzero;
        logic [DW-1:0] a;
    } dctl_t;

    logic          v_reg  [NS];
    dctl_t         c_reg  [NS];
    logic [DW-1:0] d_reg  [NS];
    logic [DW-1:0] rem_reg[NS];
    logic [DW-1:0] q_reg  [NS];

    logic aneg_w, bneg_w;
    logic [DW-1:0] ma_w, mb_w;
    assign aneg_w = in_sgn & in_a[DW-1];
    assign bneg_w = in_sgn & in_b[DW-1];
    assign ma_w   = aneg_w ? (~in_a + 1'b1) : in_a;
    assign mb_w   = bneg_w ? (~in_b + 1'b1) : in_b;

    // Stage 0 takes magnitudes; stages 1..DW each resolve one quotient bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
                v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg[0]   <= '{aneg: aneg_w, qneg: aneg_w ^ bneg_w,
                            bzero: (in_b == '0), a: in_a};
            d_reg[0]   <= mb_w;
            rem_reg[0] <= '0;
            q_reg[0]   <= ma_w;
            for (int i = 1; i < NS; i++)
            begin
                logic [DW:0] trial;
                trial = {rem_reg[i-1], q_reg[i-1][DW-1]} - {1'b0, d_reg[i-1]};
                c_reg[i] <= c_reg[i-1];
                d_reg[i] <= d_reg[i-1];
                if (trial[DW])
                begin
                    rem_reg[i] <= {rem_reg[i-1][DW-2:0], q_reg[i-1][DW-1]};
                    q_reg[i]   <= {q_reg[i-1][DW-2:0], 1'b0};
                end
                else
                begin
                    rem_reg[i] <= trial[DW-1:0];
                    q_reg[i]   <= {q_reg[i-1][DW-2:0], 1'b1};
                end
            end
        end
    end

    // Final sign fix-up and divide-by-zero result.
    always_comb
    begin
        dctl_t c;
        c = c_reg[NS-1];
        out_valid = v_reg[NS-1];
        if (c.bzero)
        begin
            out_r = c.a;
            out_q = c.aneg ? {{(DW-1){1'b0}}, 1'b1} : '1;
        end
        else
        begin
            out_q = c.qneg ? (~q_reg[NS-1] + 1'b1) : q_reg[NS-1];
            out_r = c.aneg ? (~rem_reg[NS-1] + 1'b1) : rem_reg[NS-1];
        end
    end
endmodule
`default_nettype wire
